// ----- hdl/csem_pkg.sv -----
// Shared widths, operation and status codes, cfg indices and reset values.
package csem_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 4;
    localparam int STATUS_W  = 4;
    localparam int UNITS_W   = 8;
    localparam int WAITING_W = 5;
    localparam int CFG_W     = 8;

    localparam logic [OP_W-1:0] OP_WAIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 4'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_QFULL     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_ID_BUSY   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_HANDED    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_COUNT_UP  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_FULL_ERR  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CANCELLED = 4'd7;
    localparam logic [STATUS_W-1:0] ST_CANCEL_IG = 4'd8;
    localparam logic [STATUS_W-1:0] ST_FLUSHED   = 4'd9;

    localparam logic CFG_MAX_COUNT     = 1'b0;
    localparam logic CFG_INITIAL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] MAX_COUNT_RESET     = 8'd1;
    localparam logic [CFG_W-1:0] INITIAL_COUNT_RESET = 8'd1;

endpackage

// ----- hdl/csem_req_if.sv -----
// Request channel: operation and requester id.
interface csem_req_if;
    logic                          valid;
    logic                          ready;
    logic [csem_pkg::OP_W-1:0]     op;
    logic [csem_pkg::ID_W-1:0]     waiter_id;

    modport source (output valid, op, waiter_id, input ready);
    modport sink   (input valid, op, waiter_id, output ready);
endinterface

// ----- hdl/csem_rsp_if.sv -----
// Response channel: status, affected id, unit count and queue fill.
interface csem_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [csem_pkg::STATUS_W-1:0]    status;
    logic [csem_pkg::ID_W-1:0]        granted_id;
    logic [csem_pkg::UNITS_W-1:0]     units;
    logic [csem_pkg::WAITING_W-1:0]   waiting;

    modport source (output valid, status, granted_id, units, waiting, input ready);
    modport sink   (input valid, status, granted_id, units, waiting, output ready);
endinterface

// ----- hdl/counting_semaphore_wait_queue.sv -----
// Counting semaphore with a FIFO wait queue held in RAM.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    op, waiter_id
//  rsp      out  valid/ready    status, granted_id, units, waiting
//  cfg      in   cfg_we         cfg_index, cfg_wdata
//
// Wait and cancel: mode RAM read, update, result.
// Flush, full error and release on an empty queue go straight to the result.
// Release with a non-empty queue pops until a live id or an empty queue:
// FIFO RAM read, then mode RAM read of the popped id, per entry popped.
// Reset clears the per-id mode valid bits at once; no clearing pass.
// A stalled rsp holds one result; a new request is taken meanwhile.
module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_COUNT    = 16,
    parameter int COUNT_LIMIT = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [csem_pkg::CFG_W-1:0] cfg_wdata,
    csem_req_if.sink                   req,
    csem_rsp_if.source                 rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(ID_COUNT);
    localparam int UW = csem_pkg::UNITS_W;
    localparam int SW = csem_pkg::STATUS_W;
    localparam int DW = csem_pkg::ID_W;

    localparam logic [UW-1:0] LIMIT_CAP =
        (COUNT_LIMIT > 255) ? 8'd255 : UW'(COUNT_LIMIT);
    localparam logic [UW-1:0] UNIT_RESET =
        (csem_pkg::INITIAL_COUNT_RESET > csem_pkg::MAX_COUNT_RESET) ?
        ((csem_pkg::MAX_COUNT_RESET > LIMIT_CAP) ? LIMIT_CAP : csem_pkg::MAX_COUNT_RESET) :
        ((csem_pkg::INITIAL_COUNT_RESET > LIMIT_CAP) ? LIMIT_CAP :
         csem_pkg::INITIAL_COUNT_RESET);

    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_LIVE      = 2'd1;
    localparam logic [1:0] MODE_CANCELLED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_ID,
        S_POP_MODE,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [csem_pkg::OP_W-1:0] op_reg, op_next;
    logic [DW-1:0]        id_reg, id_next;
    logic [DW-1:0]        pop_id_reg, pop_id_next;
    logic [UW-1:0]        unit_reg, unit_next;
    logic [UW-1:0]        max_count_reg, max_count_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [ID_COUNT-1:0]  mode_vld_reg, mode_vld_next;
    logic [SW-1:0]        status_reg, status_next;
    logic [DW-1:0]        who_reg, who_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SW-1:0]        out_status_reg, out_status_next;
    logic [DW-1:0]        out_who_reg, out_who_next;
    logic [UW-1:0]        out_units_reg, out_units_next;
    logic [FW-1:0]        out_fill_reg, out_fill_next;

    logic                 req_fire;
    logic [UW-1:0]        limit;
    logic                 id_ok;
    logic [IW-1:0]        id_idx;
    logic [IW-1:0]        pop_idx;
    logic [1:0]           mode_cur;

    logic                 mode_we;
    logic [IW-1:0]        mode_waddr;
    logic [1:0]           mode_wdata;
    logic [IW-1:0]        mode_raddr;
    logic [1:0]           mode_rdata;

    logic                 fifo_we;
    logic [DW-1:0]        fifo_rdata;

    csem_ram #(.WIDTH(2), .DEPTH(ID_COUNT)) u_mode_ram (
        .clk   (clk),
        .we    (mode_we),
        .waddr (mode_waddr),
        .wdata (mode_wdata),
        .raddr (mode_raddr),
        .rdata (mode_rdata)
    );

    csem_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (id_reg),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    assign req_fire   = req.valid && req.ready;
    assign req.ready  = (state_reg == S_IDLE);
    assign limit      = (max_count_reg > LIMIT_CAP) ? LIMIT_CAP : max_count_reg;
    assign id_ok      = (9'(id_reg) < 9'(ID_COUNT));
    assign id_idx     = IW'(id_reg);
    assign pop_idx    = IW'(pop_id_reg);
    assign mode_raddr = (state_reg == S_POP_ID) ? IW'(fifo_rdata) : IW'(req.waiter_id);

    always_comb
    begin
        mode_cur = MODE_IDLE;
        if (state_reg == S_POP_MODE)
        begin
            if (mode_vld_reg[pop_idx])
            begin
                mode_cur = mode_rdata;
            end
        end
        else if (id_ok && mode_vld_reg[id_idx])
        begin
            mode_cur = mode_rdata;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        pop_id_next     = pop_id_reg;
        unit_next       = unit_reg;
        max_count_next  = max_count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        mode_vld_next   = mode_vld_reg;
        status_next     = status_reg;
        who_next        = who_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_who_next    = out_who_reg;
        out_units_next  = out_units_reg;
        out_fill_next   = out_fill_reg;
        mode_we         = 1'b0;
        mode_waddr      = id_idx;
        mode_wdata      = MODE_LIVE;
        fifo_we         = 1'b0;

        // initial_count only acts at reset, where it holds its reset value
        if (cfg_we && cfg_index == csem_pkg::CFG_MAX_COUNT)
        begin
            max_count_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next  = req.op;
                    id_next  = req.waiter_id;
                    who_next = '0;
                    case (req.op)
                        csem_pkg::OP_FLUSH:
                        begin
                            head_next     = '0;
                            tail_next     = '0;
                            fill_next     = '0;
                            mode_vld_next = '0;
                            status_next   = csem_pkg::ST_FLUSHED;
                            state_next    = S_OUT;
                        end
                        csem_pkg::OP_RELEASE:
                        begin
                            if (unit_reg >= limit)
                            begin
                                status_next = csem_pkg::ST_FULL_ERR;
                                state_next  = S_OUT;
                            end
                            else if (fill_reg == '0)
                            begin
                                unit_next   = unit_reg + UW'(1);
                                status_next = csem_pkg::ST_COUNT_UP;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_POP_ID;
                            end
                        end
                        default:
                        begin
                            state_next = S_EXEC;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                who_next   = id_reg;
                state_next = S_OUT;
                if (op_reg == csem_pkg::OP_WAIT)
                begin
                    if (unit_reg != '0)
                    begin
                        unit_next   = unit_reg - UW'(1);
                        status_next = csem_pkg::ST_ACQUIRED;
                    end
                    else if (!id_ok || mode_cur != MODE_IDLE)
                    begin
                        status_next = csem_pkg::ST_ID_BUSY;
                    end
                    else if (fill_reg >= FW'(QUEUE_DEPTH))
                    begin
                        status_next = csem_pkg::ST_QFULL;
                    end
                    else
                    begin
                        fifo_we               = 1'b1;
                        tail_next             = (tail_reg == AW'(QUEUE_DEPTH - 1)) ?
                                                '0 : tail_reg + AW'(1);
                        fill_next             = fill_reg + FW'(1);
                        mode_we               = 1'b1;
                        mode_wdata            = MODE_LIVE;
                        mode_vld_next[id_idx] = 1'b1;
                        status_next           = csem_pkg::ST_QUEUED;
                    end
                end
                else
                begin
                    if (id_ok && mode_cur == MODE_LIVE)
                    begin
                        mode_we     = 1'b1;
                        mode_wdata  = MODE_CANCELLED;
                        status_next = csem_pkg::ST_CANCELLED;
                    end
                    else
                    begin
                        status_next = csem_pkg::ST_CANCEL_IG;
                    end
                end
            end
            S_POP_ID:
            begin
                pop_id_next = fifo_rdata;
                head_next   = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
                fill_next   = fill_reg - FW'(1);
                state_next  = S_POP_MODE;
            end
            S_POP_MODE:
            begin
                mode_vld_next[pop_idx] = 1'b0;
                if (mode_cur == MODE_LIVE)
                begin
                    who_next    = pop_id_reg;
                    status_next = csem_pkg::ST_HANDED;
                    state_next  = S_OUT;
                end
                else if (fill_reg != '0)
                begin
                    state_next = S_POP_ID;
                end
                else
                begin
                    unit_next   = unit_reg + UW'(1);
                    status_next = csem_pkg::ST_COUNT_UP;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_who_next    = who_reg;
                    out_units_next  = unit_reg;
                    out_fill_next   = fill_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= csem_pkg::OP_WAIT;
            id_reg         <= '0;
            pop_id_reg     <= '0;
            unit_reg       <= UNIT_RESET;
            max_count_reg  <= csem_pkg::MAX_COUNT_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            mode_vld_reg   <= '0;
            status_reg     <= csem_pkg::ST_ACQUIRED;
            who_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= csem_pkg::ST_ACQUIRED;
            out_who_reg    <= '0;
            out_units_reg  <= '0;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            pop_id_reg     <= pop_id_next;
            unit_reg       <= unit_next;
            max_count_reg  <= max_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            mode_vld_reg   <= mode_vld_next;
            status_reg     <= status_next;
            who_reg        <= who_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_who_reg    <= out_who_next;
            out_units_reg  <= out_units_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.granted_id = out_who_reg;
    assign rsp.units      = out_units_reg;
    assign rsp.waiting    = csem_pkg::WAITING_W'(out_fill_reg);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("wait queue fill above depth");

    a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) == (fill_reg == '0 || fill_reg == FW'(QUEUE_DEPTH)))
        else $error("queue pointers disagree with fill");

    a_units_cap: assert property (@(posedge clk) disable iff (!rst_n)
        unit_reg <= LIMIT_CAP)
        else $error("unit count above limit cap");

endmodule

// ----- hdl/csem_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csem_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
